// ===== rtl/core/cpt_pkg.sv =====
package cpt_pkg;

    // Quotient bits produced by the fixed-point divider and width of each output coordinate.
    localparam int QUOT_BITS = 32;
    localparam int OUT_BITS  = 32;

    // Region codes reported with every result item.
    typedef enum logic [2:0] {
        REGION_VTX_A   = 3'd0,
        REGION_VTX_B   = 3'd1,
        REGION_EDGE_AB = 3'd2,
        REGION_VTX_C   = 3'd3,
        REGION_EDGE_AC = 3'd4,
        REGION_EDGE_BC = 3'd5,
        REGION_FACE    = 3'd6
    } region_t;

endpackage

// ===== rtl/core/cpt_in_if.sv =====
interface cpt_in_if #(
    parameter int COORD_BITS = 16
) ();

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_a_z;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_b_z;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] vertex_c_z;

    modport source (
        output valid, point_x, point_y, point_z,
        output vertex_a_x, vertex_a_y, vertex_a_z,
        output vertex_b_x, vertex_b_y, vertex_b_z,
        output vertex_c_x, vertex_c_y, vertex_c_z,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z,
        input  vertex_a_x, vertex_a_y, vertex_a_z,
        input  vertex_b_x, vertex_b_y, vertex_b_z,
        input  vertex_c_x, vertex_c_y, vertex_c_z,
        output ready
    );

endinterface

// ===== rtl/core/cpt_out_if.sv =====
interface cpt_out_if import cpt_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] closest_x;
    logic signed [OUT_BITS-1:0] closest_y;
    logic signed [OUT_BITS-1:0] closest_z;
    logic [2:0]                 region;
    logic                       degenerate;

    modport source (
        output valid, closest_x, closest_y, closest_z, region, degenerate,
        input  ready
    );

    modport sink (
        input  valid, closest_x, closest_y, closest_z, region, degenerate,
        output ready
    );

endinterface

// ===== rtl/core/cpt_div.sv =====
module cpt_div import cpt_pkg::*; #(
    parameter int MAG_BITS = 88
) (
    input  logic                 clk,
    input  logic [QUOT_BITS-1:0] en,
    input  logic [MAG_BITS-1:0]  rem_in,
    input  logic [QUOT_BITS-1:0] low_in,
    input  logic [MAG_BITS-1:0]  div_in,
    output logic [QUOT_BITS-1:0] quot
);

    // One restoring step per stage: the partial remainder stays below the divisor.
    logic [MAG_BITS-1:0]  rem_reg  [QUOT_BITS];
    logic [QUOT_BITS-1:0] low_reg  [QUOT_BITS];
    logic [MAG_BITS-1:0]  div_reg  [QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_reg [QUOT_BITS];

    logic [MAG_BITS-1:0]  src_rem  [QUOT_BITS];
    logic [QUOT_BITS-1:0] src_low  [QUOT_BITS];
    logic [MAG_BITS-1:0]  src_div  [QUOT_BITS];
    logic [QUOT_BITS-1:0] src_quot [QUOT_BITS];
    logic [MAG_BITS:0]    trial    [QUOT_BITS];
    logic                 fits     [QUOT_BITS];
    logic [MAG_BITS-1:0]  rem_next [QUOT_BITS];

    // Select each stage's source and form the trial subtraction.
    always_comb
    begin
        for (int j = 0; j < QUOT_BITS; j++)
        begin
            if (j == 0)
            begin
                src_rem[j]  = rem_in;
                src_low[j]  = low_in;
                src_div[j]  = div_in;
                src_quot[j] = '0;
            end
            else
            begin
                src_rem[j]  = rem_reg[j-1];
                src_low[j]  = low_reg[j-1];
                src_div[j]  = div_reg[j-1];
                src_quot[j] = quot_reg[j-1];
            end
            trial[j] = {src_rem[j], src_low[j][QUOT_BITS-1]};
            fits[j]  = trial[j] >= {1'b0, src_div[j]};
            rem_next[j] = fits[j] ? MAG_BITS'(trial[j] - {1'b0, src_div[j]})
                                  : MAG_BITS'(trial[j]);
        end
    end

    // Stage registers advance under the pipeline enables.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QUOT_BITS; j++)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= rem_next[j];
                low_reg[j]  <= {src_low[j][QUOT_BITS-2:0], 1'b0};
                div_reg[j]  <= src_div[j];
                quot_reg[j] <= {src_quot[j][QUOT_BITS-2:0], fits[j]};
            end
        end
    end

    assign quot = quot_reg[QUOT_BITS-1];

endmodule

// ===== rtl/core/closest_point_on_triangle_core.sv =====
// Closest point on a triangle, pipelined over 46 register stages.
// Throughput: one item per cycle while the result side is ready.
// The 32 stages of the restoring divider set the depth.
// Stalls fill empty stages first, so items are still taken while a result waits.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
module closest_point_on_triangle_core import cpt_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    cpt_in_if.sink    query,
    cpt_out_if.source result
);

    localparam int CW  = COORD_BITS;
    localparam int DFW = CW + 1;
    localparam int PW  = 2 * CW + 2;
    localparam int DW  = 2 * CW + 3;
    localparam int TBW = DW + 1;
    localparam int VW  = 4 * CW + 6;
    localparam int EW  = 4 * CW + 7;
    localparam int XW  = 5 * CW + 8;
    localparam int L1  = DW / 2;
    localparam int H1  = DW - L1;
    localparam int L2  = EW / 2;
    localparam int H2  = EW - L2;
    localparam int L3  = VW / 2;
    localparam int H3  = VW - L3;
    localparam int DIV_FIRST = 13;
    localparam int NSTG      = DIV_FIRST + QUOT_BITS + 1;
    localparam int OUT_STG   = NSTG - 1;
    localparam int MX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int MY [6] = '{3, 1, 1, 5, 5, 3};
    localparam logic [OUT_BITS-1:0] POS_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] NEG_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef struct packed {
        logic [2:0][CW-1:0]  a;
        logic [2:0][CW-1:0]  b;
        logic [2:0][CW-1:0]  c;
        logic [2:0][DFW-1:0] ab;
        logic [2:0][DFW-1:0] ac;
        logic [2:0][DFW-1:0] bc;
    } geo_t;

    typedef struct packed {
        logic fa;
        logic fb;
        logic fc;
        logic gab;
        logic gac;
        logic gbc;
    } flag_t;

    typedef struct packed {
        region_t    region;
        logic       degen;
        logic [2:0] neg;
        logic [2:0] ovf;
    } side_t;

    // Flow control: a stage loads when it is empty or its item moves on.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] en;

    assign rdy[NSTG] = result.ready;
    for (genvar i = 0; i < NSTG; i++)
    begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
    end
    assign en          = rdy[NSTG-1:0];
    assign query.ready = rdy[0];

    always_comb
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            if (!rdy[i])
                vld_next[i] = vld_reg[i];
            else if (i == 0)
                vld_next[i] = query.valid;
            else
                vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Stage 0: capture the query item.
    logic signed [CW-1:0] s0_p_reg [3];
    logic signed [CW-1:0] s0_a_reg [3];
    logic signed [CW-1:0] s0_b_reg [3];
    logic signed [CW-1:0] s0_c_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_p_reg[0] <= query.point_x;
            s0_p_reg[1] <= query.point_y;
            s0_p_reg[2] <= query.point_z;
            s0_a_reg[0] <= query.vertex_a_x;
            s0_a_reg[1] <= query.vertex_a_y;
            s0_a_reg[2] <= query.vertex_a_z;
            s0_b_reg[0] <= query.vertex_b_x;
            s0_b_reg[1] <= query.vertex_b_y;
            s0_b_reg[2] <= query.vertex_b_z;
            s0_c_reg[0] <= query.vertex_c_x;
            s0_c_reg[1] <= query.vertex_c_y;
            s0_c_reg[2] <= query.vertex_c_z;
        end
    end

    // Stage 1: edge and offset vectors.
    geo_t                  geo_reg [6];
    logic signed [DFW-1:0] s1_ap_reg [3];
    logic signed [DFW-1:0] s1_bp_reg [3];
    logic signed [DFW-1:0] s1_cp_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                geo_reg[0].a[k]  <= s0_a_reg[k];
                geo_reg[0].b[k]  <= s0_b_reg[k];
                geo_reg[0].c[k]  <= s0_c_reg[k];
                geo_reg[0].ab[k] <= DFW'(s0_b_reg[k]) - DFW'(s0_a_reg[k]);
                geo_reg[0].ac[k] <= DFW'(s0_c_reg[k]) - DFW'(s0_a_reg[k]);
                geo_reg[0].bc[k] <= DFW'(s0_c_reg[k]) - DFW'(s0_b_reg[k]);
                s1_ap_reg[k]     <= DFW'(s0_p_reg[k]) - DFW'(s0_a_reg[k]);
                s1_bp_reg[k]     <= DFW'(s0_p_reg[k]) - DFW'(s0_b_reg[k]);
                s1_cp_reg[k]     <= DFW'(s0_p_reg[k]) - DFW'(s0_c_reg[k]);
            end
        end
    end

    // Geometry rides along until the region is chosen.
    always_ff @(posedge clk)
    begin
        for (int i = 1; i < 6; i++)
        begin
            if (en[i+1])
                geo_reg[i] <= geo_reg[i-1];
        end
    end

    // Stage 2: per-axis products of the six dot products.
    logic signed [PW-1:0] s2_m_reg [6][3];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_m_reg[0][k] <= $signed(geo_reg[0].ab[k]) * s1_ap_reg[k];
                s2_m_reg[1][k] <= $signed(geo_reg[0].ac[k]) * s1_ap_reg[k];
                s2_m_reg[2][k] <= $signed(geo_reg[0].ab[k]) * s1_bp_reg[k];
                s2_m_reg[3][k] <= $signed(geo_reg[0].ac[k]) * s1_bp_reg[k];
                s2_m_reg[4][k] <= $signed(geo_reg[0].ab[k]) * s1_cp_reg[k];
                s2_m_reg[5][k] <= $signed(geo_reg[0].ac[k]) * s1_cp_reg[k];
            end
        end
    end

    // Stage 3: dot products d1 to d6.
    logic signed [DW-1:0] s3_d_reg [6];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int j = 0; j < 6; j++)
                s3_d_reg[j] <= DW'(s2_m_reg[j][0]) + DW'(s2_m_reg[j][1])
                             + DW'(s2_m_reg[j][2]);
        end
    end

    // Stage 4: split partial products of the barycentric terms, plus region flags.
    logic signed [DW+L1:0]   s4_pl_reg [6];
    logic signed [DW+H1-1:0] s4_ph_reg [6];
    flag_t                   s4_flag_reg;
    logic signed [DW-1:0]    s4_d1_reg;
    logic signed [DW-1:0]    s4_d2_reg;
    logic signed [DW-1:0]    s4_d3_reg;
    logic signed [DW-1:0]    s4_d6_reg;
    logic signed [TBW-1:0]   s4_tbc_reg;
    logic signed [TBW-1:0]   s4_ubc_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int j = 0; j < 6; j++)
            begin
                s4_pl_reg[j] <= s3_d_reg[MX[j]] * $signed({1'b0, s3_d_reg[MY[j]][L1-1:0]});
                s4_ph_reg[j] <= s3_d_reg[MX[j]] * $signed(s3_d_reg[MY[j]][DW-1:L1]);
            end
            s4_flag_reg.fa  <= (s3_d_reg[0] <= 0) && (s3_d_reg[1] <= 0);
            s4_flag_reg.fb  <= (s3_d_reg[2] >= 0) && (s3_d_reg[3] <= s3_d_reg[2]);
            s4_flag_reg.fc  <= (s3_d_reg[5] >= 0) && (s3_d_reg[4] <= s3_d_reg[5]);
            s4_flag_reg.gab <= (s3_d_reg[0] >= 0) && (s3_d_reg[2] <= 0);
            s4_flag_reg.gac <= (s3_d_reg[1] >= 0) && (s3_d_reg[5] <= 0);
            s4_flag_reg.gbc <= (s3_d_reg[3] >= s3_d_reg[2]) && (s3_d_reg[4] >= s3_d_reg[5]);
            s4_d1_reg  <= s3_d_reg[0];
            s4_d2_reg  <= s3_d_reg[1];
            s4_d3_reg  <= s3_d_reg[2];
            s4_d6_reg  <= s3_d_reg[5];
            s4_tbc_reg <= TBW'(s3_d_reg[3]) - TBW'(s3_d_reg[2]);
            s4_ubc_reg <= TBW'(s3_d_reg[4]) - TBW'(s3_d_reg[5]);
        end
    end

    // Stage 5: full products and the edge divisors.
    logic signed [VW-1:0]  s5_prod_reg [6];
    flag_t                 s5_flag_reg;
    logic signed [DW-1:0]  s5_d1_reg;
    logic signed [DW-1:0]  s5_d2_reg;
    logic signed [TBW-1:0] s5_tbc_reg;
    logic signed [EW-1:0]  s5_den_ab_reg;
    logic signed [EW-1:0]  s5_den_ac_reg;
    logic signed [EW-1:0]  s5_den_bc_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int j = 0; j < 6; j++)
                s5_prod_reg[j] <= (VW'(s4_ph_reg[j]) <<< L1) + VW'(s4_pl_reg[j]);
            s5_flag_reg     <= s4_flag_reg;
            s5_d1_reg       <= s4_d1_reg;
            s5_d2_reg       <= s4_d2_reg;
            s5_tbc_reg      <= s4_tbc_reg;
            s5_den_ab_reg   <= EW'(s4_d1_reg) - EW'(s4_d3_reg);
            s5_den_ac_reg   <= EW'(s4_d2_reg) - EW'(s4_d6_reg);
            s5_den_bc_reg   <= EW'(s4_tbc_reg) + EW'(s4_ubc_reg);
        end
    end

    // Stage 6: barycentric numerators va, vb and vc.
    logic signed [VW-1:0]  s6_va_reg;
    logic signed [VW-1:0]  s6_vb_reg;
    logic signed [VW-1:0]  s6_vc_reg;
    flag_t                 s6_flag_reg;
    logic signed [DW-1:0]  s6_d1_reg;
    logic signed [DW-1:0]  s6_d2_reg;
    logic signed [TBW-1:0] s6_tbc_reg;
    logic signed [EW-1:0]  s6_den_ab_reg;
    logic signed [EW-1:0]  s6_den_ac_reg;
    logic signed [EW-1:0]  s6_den_bc_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_vc_reg     <= s5_prod_reg[0] - s5_prod_reg[1];
            s6_vb_reg     <= s5_prod_reg[2] - s5_prod_reg[3];
            s6_va_reg     <= s5_prod_reg[4] - s5_prod_reg[5];
            s6_flag_reg   <= s5_flag_reg;
            s6_d1_reg     <= s5_d1_reg;
            s6_d2_reg     <= s5_d2_reg;
            s6_tbc_reg    <= s5_tbc_reg;
            s6_den_ab_reg <= s5_den_ab_reg;
            s6_den_ac_reg <= s5_den_ac_reg;
            s6_den_bc_reg <= s5_den_bc_reg;
        end
    end

    // Region decision, in priority order, and selection of the projection terms.
    region_t               region_next;
    logic signed [CW-1:0]  base_next [3];
    logic signed [DFW-1:0] e1_next [3];
    logic signed [DFW-1:0] e2_next [3];
    logic signed [VW-1:0]  t1_next;
    logic signed [VW-1:0]  t2_next;
    logic signed [EW-1:0]  den_next;

    always_comb
    begin
        region_next = REGION_FACE;
        t1_next     = s6_vb_reg;
        t2_next     = s6_vc_reg;
        den_next    = EW'(s6_va_reg) + EW'(s6_vb_reg) + EW'(s6_vc_reg);
        for (int k = 0; k < 3; k++)
        begin
            base_next[k] = $signed(geo_reg[5].a[k]);
            e1_next[k]   = $signed(geo_reg[5].ab[k]);
            e2_next[k]   = $signed(geo_reg[5].ac[k]);
        end
        if (s6_flag_reg.fa || s6_flag_reg.fb || s6_flag_reg.fc)
        begin
            t1_next  = '0;
            t2_next  = '0;
            den_next = EW'(1);
            for (int k = 0; k < 3; k++)
            begin
                e1_next[k] = '0;
                e2_next[k] = '0;
            end
            if (s6_flag_reg.fa)
                region_next = REGION_VTX_A;
            else if (s6_flag_reg.fb)
                region_next = REGION_VTX_B;
        end
        if (s6_flag_reg.fa)
        begin
            region_next = REGION_VTX_A;
        end
        else if (s6_flag_reg.fb)
        begin
            region_next = REGION_VTX_B;
            for (int k = 0; k < 3; k++)
                base_next[k] = $signed(geo_reg[5].b[k]);
        end
        else if ((s6_vc_reg <= 0) && s6_flag_reg.gab)
        begin
            region_next = REGION_EDGE_AB;
            t1_next     = VW'(s6_d1_reg);
            t2_next     = '0;
            den_next    = s6_den_ab_reg;
            for (int k = 0; k < 3; k++)
            begin
                e1_next[k] = $signed(geo_reg[5].ab[k]);
                e2_next[k] = '0;
            end
        end
        else if (s6_flag_reg.fc)
        begin
            region_next = REGION_VTX_C;
            for (int k = 0; k < 3; k++)
                base_next[k] = $signed(geo_reg[5].c[k]);
        end
        else if ((s6_vb_reg <= 0) && s6_flag_reg.gac)
        begin
            region_next = REGION_EDGE_AC;
            t1_next     = VW'(s6_d2_reg);
            t2_next     = '0;
            den_next    = s6_den_ac_reg;
            for (int k = 0; k < 3; k++)
            begin
                e1_next[k] = $signed(geo_reg[5].ac[k]);
                e2_next[k] = '0;
            end
        end
        else if ((s6_va_reg <= 0) && s6_flag_reg.gbc)
        begin
            region_next = REGION_EDGE_BC;
            t1_next     = VW'(s6_tbc_reg);
            t2_next     = '0;
            den_next    = s6_den_bc_reg;
            for (int k = 0; k < 3; k++)
            begin
                base_next[k] = $signed(geo_reg[5].b[k]);
                e1_next[k]   = $signed(geo_reg[5].bc[k]);
                e2_next[k]   = '0;
            end
        end
    end

    // Stage 7: selected base vertex, edge terms and divisor.
    region_t               s7_region_reg;
    logic signed [CW-1:0]  s7_base_reg [3];
    logic signed [DFW-1:0] s7_e1_reg [3];
    logic signed [DFW-1:0] s7_e2_reg [3];
    logic signed [VW-1:0]  s7_t1_reg;
    logic signed [VW-1:0]  s7_t2_reg;
    logic signed [EW-1:0]  s7_den_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_region_reg <= region_next;
            s7_base_reg   <= base_next;
            s7_e1_reg     <= e1_next;
            s7_e2_reg     <= e2_next;
            s7_t1_reg     <= t1_next;
            s7_t2_reg     <= t2_next;
            s7_den_reg    <= den_next;
        end
    end

    // Stage 8: split partial products of the numerator, zero-divisor check.
    logic signed [CW+L2:0]    s8_blo_reg [3];
    logic signed [CW+H2-1:0]  s8_bhi_reg [3];
    logic signed [DFW+L3:0]   s8_e1lo_reg [3];
    logic signed [DFW+H3-1:0] s8_e1hi_reg [3];
    logic signed [DFW+L3:0]   s8_e2lo_reg [3];
    logic signed [DFW+H3-1:0] s8_e2hi_reg [3];
    logic signed [CW-1:0]     s8_base_reg [3];
    logic signed [EW-1:0]     s8_den_reg;
    region_t                  s8_region_reg;
    logic                     s8_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s8_blo_reg[k]  <= s7_base_reg[k] * $signed({1'b0, s7_den_reg[L2-1:0]});
                s8_bhi_reg[k]  <= s7_base_reg[k] * $signed(s7_den_reg[EW-1:L2]);
                s8_e1lo_reg[k] <= s7_e1_reg[k] * $signed({1'b0, s7_t1_reg[L3-1:0]});
                s8_e1hi_reg[k] <= s7_e1_reg[k] * $signed(s7_t1_reg[VW-1:L3]);
                s8_e2lo_reg[k] <= s7_e2_reg[k] * $signed({1'b0, s7_t2_reg[L3-1:0]});
                s8_e2hi_reg[k] <= s7_e2_reg[k] * $signed(s7_t2_reg[VW-1:L3]);
            end
            s8_base_reg   <= s7_base_reg;
            s8_den_reg    <= s7_den_reg;
            s8_region_reg <= s7_region_reg;
            s8_degen_reg  <= (s7_den_reg == '0);
        end
    end

    // Stage 9: recombine the partial products.
    logic signed [XW-1:0] s9_q_reg [3][3];
    logic signed [CW-1:0] s9_base_reg [3];
    logic signed [EW-1:0] s9_den_reg;
    region_t              s9_region_reg;
    logic                 s9_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s9_q_reg[0][k] <= (XW'(s8_bhi_reg[k]) <<< L2) + XW'(s8_blo_reg[k]);
                s9_q_reg[1][k] <= (XW'(s8_e1hi_reg[k]) <<< L3) + XW'(s8_e1lo_reg[k]);
                s9_q_reg[2][k] <= (XW'(s8_e2hi_reg[k]) <<< L3) + XW'(s8_e2lo_reg[k]);
            end
            s9_base_reg   <= s8_base_reg;
            s9_den_reg    <= s8_den_reg;
            s9_region_reg <= s8_region_reg;
            s9_degen_reg  <= s8_degen_reg;
        end
    end

    // Stage 10: numerator of each coordinate.
    logic signed [XW-1:0] s10_x_reg [3];
    logic signed [CW-1:0] s10_base_reg [3];
    logic signed [EW-1:0] s10_den_reg;
    region_t              s10_region_reg;
    logic                 s10_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            for (int k = 0; k < 3; k++)
                s10_x_reg[k] <= s9_q_reg[0][k] + s9_q_reg[1][k] + s9_q_reg[2][k];
            s10_base_reg   <= s9_base_reg;
            s10_den_reg    <= s9_den_reg;
            s10_region_reg <= s9_region_reg;
            s10_degen_reg  <= s9_degen_reg;
        end
    end

    // A zero divisor falls back to the region's first vertex over a unit divisor.
    logic signed [XW-1:0] xs [3];
    logic signed [XW-1:0] ds;

    always_comb
    begin
        ds = s10_degen_reg ? XW'(1) : XW'(s10_den_reg);
        for (int k = 0; k < 3; k++)
            xs[k] = s10_degen_reg ? XW'(s10_base_reg[k]) : s10_x_reg[k];
    end

    // Stage 11: magnitudes and result signs.
    logic [XW-1:0] s11_mx_reg [3];
    logic [XW-1:0] s11_md_reg;
    logic [2:0]    s11_neg_reg;
    region_t       s11_region_reg;
    logic          s11_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s11_mx_reg[k]  <= xs[k][XW-1] ? (~xs[k] + 1'b1) : xs[k];
                s11_neg_reg[k] <= xs[k][XW-1] ^ ds[XW-1];
            end
            s11_md_reg     <= ds[XW-1] ? (~ds + 1'b1) : ds;
            s11_region_reg <= s10_region_reg;
            s11_degen_reg  <= s10_degen_reg;
        end
    end

    // Stage 12: overflow check and divider setup for the scaled dividend.
    logic [XW-1:0]        s12_rem_reg [3];
    logic [QUOT_BITS-1:0] s12_low_reg [3];
    logic [XW-1:0]        s12_md_reg;
    side_t                s12_side_reg;

    always_ff @(posedge clk)
    begin
        if (en[12])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s12_rem_reg[k]      <= s11_mx_reg[k] >> (QUOT_BITS - FRAC_BITS);
                s12_low_reg[k]      <= QUOT_BITS'({s11_mx_reg[k], {FRAC_BITS{1'b0}}});
                s12_side_reg.ovf[k] <= (s11_mx_reg[k] >> (QUOT_BITS - FRAC_BITS))
                                       >= s11_md_reg;
            end
            s12_md_reg          <= s11_md_reg;
            s12_side_reg.neg    <= s11_neg_reg;
            s12_side_reg.region <= s11_region_reg;
            s12_side_reg.degen  <= s11_degen_reg;
        end
    end

    // Stages 13 to 44: one quotient bit per stage for each coordinate.
    logic [QUOT_BITS-1:0] quot [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        cpt_div #(
            .MAG_BITS (XW)
        ) u_div (
            .clk    (clk),
            .en     (en[DIV_FIRST +: QUOT_BITS]),
            .rem_in (s12_rem_reg[k]),
            .low_in (s12_low_reg[k]),
            .div_in (s12_md_reg),
            .quot   (quot[k])
        );
    end

    side_t side_reg [QUOT_BITS];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QUOT_BITS; j++)
        begin
            if (en[DIV_FIRST + j])
                side_reg[j] <= (j == 0) ? s12_side_reg : side_reg[(j == 0) ? 0 : j - 1];
        end
    end

    // Sign and saturation to the signed 32-bit output range.
    logic [OUT_BITS-1:0] coord_next [3];
    side_t               side_last;

    always_comb
    begin
        side_last = side_reg[QUOT_BITS-1];
        for (int k = 0; k < 3; k++)
        begin
            if (side_last.neg[k])
            begin
                if (side_last.ovf[k] || (quot[k][QUOT_BITS-1] && |quot[k][QUOT_BITS-2:0]))
                    coord_next[k] = NEG_MIN;
                else
                    coord_next[k] = OUT_BITS'(~quot[k] + 1'b1);
            end
            else
            begin
                if (side_last.ovf[k] || quot[k][QUOT_BITS-1])
                    coord_next[k] = POS_MAX;
                else
                    coord_next[k] = OUT_BITS'(quot[k]);
            end
        end
    end

    // Stage 45: output register.
    logic [OUT_BITS-1:0] out_coord_reg [3];
    region_t             out_region_reg;
    logic                out_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en[OUT_STG])
        begin
            out_coord_reg  <= coord_next;
            out_region_reg <= side_last.region;
            out_degen_reg  <= side_last.degen;
        end
    end

    assign result.valid      = vld_reg[OUT_STG];
    assign result.closest_x  = out_coord_reg[0];
    assign result.closest_y  = out_coord_reg[1];
    assign result.closest_z  = out_coord_reg[2];
    assign result.region     = out_region_reg;
    assign result.degenerate = out_degen_reg;

endmodule

// ===== tb/sv/closest_point_checker.sv =====
module closest_point_checker
    import cpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cpt_in_if    query,
    cpt_out_if   result,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        region_t     rg;
        logic        dg;
    } closest_t;

    closest_t closest_q[$];

    // Truncated fixed-point quotient x * 2^16 / d, saturated to 32 bits.
    function automatic logic [31:0] fix_quot(wide_t x, wide_t d);
        logic  neg;
        wide_t mx;
        wide_t md;
        wide_t q;
        neg = (x < 0) != (d < 0);
        mx = (x < 0) ? -x : x;
        md = (d < 0) ? -d : d;
        q = (mx <<< 16) / md;
        if (!neg && q > 160'sd2147483647)
            return 32'h7fffffff;
        if (neg && q > 160'sd2147483648)
            return 32'h80000000;
        return neg ? 32'(-q) : 32'(q);
    endfunction

    // Point (base*den + e1*t1 + e2*t2) / den on all three axes.
    function automatic void project(ref closest_t r, input longint base[3],
                                    input longint e1[3], input wide_t t1,
                                    input longint e2[3], input wide_t t2,
                                    input wide_t den);
        wide_t x[3];
        for (int k = 0; k < 3; k++)
        begin
            x[k] = wide_t'(base[k]) * den + wide_t'(e1[k]) * t1 + wide_t'(e2[k]) * t2;
        end
        r.cx = fix_quot(x[0], den);
        r.cy = fix_quot(x[1], den);
        r.cz = fix_quot(x[2], den);
    endfunction

    function automatic longint dot(longint u[3], longint v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // Voronoi-region classification and projection of one query item.
    function automatic closest_t predict_closest(longint p[3], longint a[3],
                                                 longint b[3], longint c[3]);
        closest_t r;
        longint   ab[3], ac[3], ap[3], bp[3], cp[3], bc[3], nul[3];
        longint   d1, d2, d3, d4, d5, d6;
        wide_t    va, vb, vc, den;
        for (int k = 0; k < 3; k++)
        begin
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
            bc[k] = c[k] - b[k];
            nul[k] = 0;
        end
        r.dg = 1'b0;
        d1 = dot(ab, ap);
        d2 = dot(ac, ap);
        if (d1 <= 0 && d2 <= 0)
        begin
            r.rg = REGION_VTX_A;
            project(r, a, nul, 0, nul, 0, 1);
            return r;
        end
        d3 = dot(ab, bp);
        d4 = dot(ac, bp);
        if (d3 >= 0 && d4 <= d3)
        begin
            r.rg = REGION_VTX_B;
            project(r, b, nul, 0, nul, 0, 1);
            return r;
        end
        vc = wide_t'(d1) * wide_t'(d4) - wide_t'(d3) * wide_t'(d2);
        if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            r.rg = REGION_EDGE_AB;
            den = d1 - d3;
            r.dg = (den == 0);
            if (r.dg)
                project(r, a, nul, 0, nul, 0, 1);
            else
                project(r, a, ab, d1, nul, 0, den);
            return r;
        end
        d5 = dot(ab, cp);
        d6 = dot(ac, cp);
        if (d6 >= 0 && d5 <= d6)
        begin
            r.rg = REGION_VTX_C;
            project(r, c, nul, 0, nul, 0, 1);
            return r;
        end
        vb = wide_t'(d5) * wide_t'(d2) - wide_t'(d1) * wide_t'(d6);
        if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            r.rg = REGION_EDGE_AC;
            den = d2 - d6;
            r.dg = (den == 0);
            if (r.dg)
                project(r, a, nul, 0, nul, 0, 1);
            else
                project(r, a, ac, d2, nul, 0, den);
            return r;
        end
        va = wide_t'(d3) * wide_t'(d6) - wide_t'(d5) * wide_t'(d4);
        if (va <= 0 && (d4 - d3) >= 0 && (d5 - d6) >= 0)
        begin
            r.rg = REGION_EDGE_BC;
            den = (d4 - d3) + (d5 - d6);
            r.dg = (den == 0);
            if (r.dg)
                project(r, b, nul, 0, nul, 0, 1);
            else
                project(r, b, bc, d4 - d3, nul, 0, den);
            return r;
        end
        r.rg = REGION_FACE;
        den = va + vb + vc;
        r.dg = (den == 0);
        if (r.dg)
            project(r, a, nul, 0, nul, 0, 1);
        else
            project(r, a, ab, vb, ac, vc, den);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending = closest_q.size();

    initial fail_count = 0;

    // Predict on every accepted query item.
    always @(posedge clk)
    begin
        longint p[3], a[3], b[3], c[3];
        if (rst_n && query.valid && query.ready)
        begin
            p = '{query.point_x, query.point_y, query.point_z};
            a = '{query.vertex_a_x, query.vertex_a_y, query.vertex_a_z};
            b = '{query.vertex_b_x, query.vertex_b_y, query.vertex_b_z};
            c = '{query.vertex_c_x, query.vertex_c_y, query.vertex_c_z};
            closest_q = {closest_q, predict_closest(p, a, b, c)};
        end
    end

    // Compare every accepted result item with the oldest prediction.
    always @(posedge clk)
    begin
        closest_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (closest_q.size() == 0)
            begin
                $display("[%0t] result item with no query outstanding", $realtime);
                fail_count++;
            end
            else
            begin
                want = closest_q.pop_front();
                if (result.closest_x !== want.cx)
                    report_mismatch("closest_x", result.closest_x, want.cx);
                if (result.closest_y !== want.cy)
                    report_mismatch("closest_y", result.closest_y, want.cy);
                if (result.closest_z !== want.cz)
                    report_mismatch("closest_z", result.closest_z, want.cz);
                if (result.region !== want.rg)
                    report_mismatch("region", 32'(result.region), 32'(want.rg));
                if (result.degenerate !== want.dg)
                    report_mismatch("degenerate", 32'(result.degenerate), 32'(want.dg));
            end
        end
    end

endmodule

// ===== tb/sv/closest_point_on_triangle_core_test.sv =====
module closest_point_on_triangle_core_test;
    import cpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_LIMIT  = 2000;

    typedef logic signed [15:0] coord_t;

    logic clk;
    logic rst_n;
    logic idle_en;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    int   stall_left;

    cpt_in_if #(.COORD_BITS(16)) query_ch ();
    cpt_out_if                   result_ch ();

    closest_point_on_triangle_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    closest_point_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hand one query item to the block and hold it until accepted.
    task automatic send_query(coord_t p[3], coord_t a[3], coord_t b[3], coord_t c[3]);
        logic took;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            query_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        query_ch.valid      <= 1'b1;
        query_ch.point_x    <= p[0];
        query_ch.point_y    <= p[1];
        query_ch.point_z    <= p[2];
        query_ch.vertex_a_x <= a[0];
        query_ch.vertex_a_y <= a[1];
        query_ch.vertex_a_z <= a[2];
        query_ch.vertex_b_x <= b[0];
        query_ch.vertex_b_y <= b[1];
        query_ch.vertex_b_z <= b[2];
        query_ch.vertex_c_x <= c[0];
        query_ch.vertex_c_y <= c[1];
        query_ch.vertex_c_z <= c[2];
        forever
        begin
            @(negedge clk);
            took = query_ch.ready;
            @(posedge clk);
            if (took)
                break;
        end
    endtask

    function automatic coord_t near(coord_t center, int span);
        int v;
        v = int'(center) + $urandom_range(0, 2 * span) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return coord_t'(v);
    endfunction

    // One random query: mostly small well-formed triangles, some wide and some degenerate.
    task automatic send_random_query();
        coord_t p[3], a[3], b[3], c[3], o[3];
        int     mode;
        int     span;
        int     k;
        mode = $urandom_range(0, 9);
        span = ($urandom_range(0, 1) == 0) ? 64 : 4000;
        for (k = 0; k < 3; k++)
        begin
            o[k] = coord_t'($urandom);
            a[k] = near(o[k], span);
            b[k] = near(o[k], span);
            c[k] = near(o[k], span);
            p[k] = near(o[k], 2 * span);
        end
        if (mode <= 1)
        begin
            for (k = 0; k < 3; k++)
            begin
                a[k] = coord_t'($urandom);
                b[k] = coord_t'($urandom);
                c[k] = coord_t'($urandom);
                p[k] = coord_t'($urandom);
            end
        end
        else if (mode == 2)
        begin
            // Coincident vertices.
            case ($urandom_range(0, 3))
                0: b = a;
                1: c = a;
                2: c = b;
                default: begin b = a; c = a; end
            endcase
        end
        else if (mode == 3)
        begin
            // Collinear vertices.
            for (k = 0; k < 3; k++)
            begin
                b[k] = near(a[k], 30);
                c[k] = coord_t'(int'(a[k]) + 2 * (int'(b[k]) - int'(a[k])));
            end
        end
        else if (mode == 4)
        begin
            // Query point inside the face, near its centroid.
            for (k = 0; k < 3; k++)
                p[k] = coord_t'((int'(a[k]) + int'(b[k]) + int'(c[k])) / 3);
        end
        send_query(p, a, b, c);
    endtask

    // Result side stalls in random bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            result_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_ch.ready <= (stall_left == 1);
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 6);
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no item moving on either channel.
    always @(posedge clk)
    begin
        if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("closest_point_on_triangle_core verification failed");
            $finish;
        end
    end

    initial
    begin
        coord_t z[3];
        coord_t lo[3];
        coord_t hi[3];
        z  = '{0, 0, 0};
        lo = '{-32768, -32768, -32768};
        hi = '{32767, 32767, 32767};
        idle_en = 1'b0;
        quiet_cycles = 0;
        stall_left = 0;
        rst_n = 1'b0;
        result_ch.ready = 1'b1;
        query_ch.valid = 1'b0;
        query_ch.point_x = '0;
        query_ch.point_y = '0;
        query_ch.point_z = '0;
        query_ch.vertex_a_x = '0;
        query_ch.vertex_a_y = '0;
        query_ch.vertex_a_z = '0;
        query_ch.vertex_b_x = '0;
        query_ch.vertex_b_y = '0;
        query_ch.vertex_b_z = '0;
        query_ch.vertex_c_x = '0;
        query_ch.vertex_c_y = '0;
        query_ch.vertex_c_z = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each region of a plain right triangle.
        send_query('{-10, -10, 5}, z, '{100, 0, 0}, '{0, 100, 0});
        send_query('{120, -10, 0}, z, '{100, 0, 0}, '{0, 100, 0});
        send_query('{50, -20, 7}, z, '{100, 0, 0}, '{0, 100, 0});
        send_query('{-10, 120, 0}, z, '{100, 0, 0}, '{0, 100, 0});
        send_query('{-20, 50, -3}, z, '{100, 0, 0}, '{0, 100, 0});
        send_query('{60, 60, 0}, z, '{100, 0, 0}, '{0, 100, 0});
        send_query('{20, 33, 30}, z, '{100, 0, 0}, '{0, 100, 0});
        // Ties on region borders.
        send_query(z, z, '{100, 0, 0}, '{0, 100, 0});
        send_query('{50, 50, 0}, z, '{100, 0, 0}, '{0, 100, 0});
        send_query('{50, 0, 0}, z, '{100, 0, 0}, '{0, 100, 0});
        // Degenerate triangles: all coincident, two coincident, collinear.
        send_query(z, z, z, z);
        send_query('{5, 5, 0}, z, z, '{10, 0, 0});
        send_query('{3, 9, -2}, '{7, 7, 7}, '{7, 7, 7}, '{7, 7, 7});
        send_query('{15, 5, 0}, z, '{10, 0, 0}, '{20, 0, 0});
        send_query('{5, 5, 0}, '{10, 0, 0}, z, z);
        send_query('{12, 4, 1}, '{-20, 0, 0}, '{10, 0, 0}, '{10, 0, 0});
        // Coordinate extremes.
        send_query(lo, lo, lo, lo);
        send_query(hi, hi, hi, hi);
        send_query(hi, lo, '{32767, -32768, 32767}, '{-32768, 32767, 32767});
        send_query(lo, hi, '{-32768, 32767, -32768}, '{32767, -32768, -32768});
        send_query('{0, 0, 32767}, lo, '{32767, -32768, 0}, '{-32768, 32767, 0});
        send_query('{-1, -1, -1}, '{-32768, 0, 32767}, '{32767, 0, -32768}, '{0, 32767, 0});

        // Random part with idling on both sides, then a final stretch without.
        idle_en = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 120)
                idle_en = 1'b0;
            send_random_query();
        end
        query_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("closest_point_on_triangle_core verification clean");
        else
            $display("closest_point_on_triangle_core verification failed");
        $finish;
    end

endmodule
